[sv/plct_pkg.sv]
// Shared types and constants for the piecewise linear color table.
package plct_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SLOT = 2'd2;
    localparam logic [1:0] ST_FEW  = 2'd3;

    localparam logic [7:0] CH_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] position;
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [3:0] point_slot;
        logic [7:0] entry_index;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic [4:0] point_count;
    } t_out;

    // Control point: channels in table order red, green, blue, alpha
    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_point;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_SORT, S_CLEAR, S_SEG, S_PUTA, S_PUTB,
        S_DIV, S_INTERP, S_ROT, S_RESTORE, S_FIN, S_RESP
    } t_state;

    typedef struct packed {
        logic latch;
        logic apply;
        logic sort_step;
        logic clr_step;
        logic put_a;
        logic put_b;
        logic div_step;
        logic interp_step;
        logic rotate;
        logic rot_clr;
    } t_cmd;

    typedef struct packed {
        logic rebuild;
        logic sort_last;
        logic clr_last;
        logic seg_more;
        logic div_last;
        logic interp_run;
        logic rot_full;
    } t_sts;

    // Select one channel of a point by lane number
    function automatic logic [7:0] point_ch(input t_point p, input logic [1:0] c);
        logic [7:0] v;
        unique case (c)
            2'd0: v = p.red;
            2'd1: v = p.green;
            2'd2: v = p.blue;
            default: v = p.alpha;
        endcase
        return v;
    endfunction

endpackage

[sv/plct_ctrl.sv]
// Sequencer for item decode, sort, table clear, segment fill, point restore and response.
module plct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  plct_pkg::t_sts  i_sts,
    output plct_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);
    import plct_pkg::*;

    t_state r_state, n_state;
    logic   r_boot;

    // State register; reset runs the initial table build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN) r_boot <= 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_start) n_state = S_DECIDE;
            S_DECIDE:  n_state = i_sts.rebuild ? S_SORT : S_RESP;
            S_SORT:    if (i_sts.sort_last) n_state = S_CLEAR;
            S_CLEAR:   if (i_sts.clr_last) n_state = S_SEG;
            S_SEG:     n_state = i_sts.seg_more ? S_PUTA : S_RESTORE;
            S_PUTA:    n_state = S_PUTB;
            S_PUTB:    n_state = S_DIV;
            S_DIV:     if (i_sts.div_last) n_state = S_INTERP;
            S_INTERP:  if (!i_sts.interp_run) n_state = S_ROT;
            S_ROT:     n_state = S_SEG;
            S_RESTORE: if (i_sts.rot_full) n_state = S_FIN;
            S_FIN:     n_state = r_boot ? S_IDLE : S_RESP;
            S_RESP:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd   = '0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE:    o_cmd.latch = i_start;
            S_DECIDE:  o_cmd.apply = 1'b1;
            S_SORT:    o_cmd.sort_step = 1'b1;
            S_CLEAR:   o_cmd.clr_step = 1'b1;
            S_PUTA:    o_cmd.put_a = 1'b1;
            S_PUTB:    o_cmd.put_b = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_INTERP:  o_cmd.interp_step = i_sts.interp_run;
            S_ROT:     o_cmd.rotate = 1'b1;
            S_RESTORE: o_cmd.rotate = !i_sts.rot_full;
            S_FIN:     o_cmd.rot_clr = 1'b1;
            S_RESP:    o_valid = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[sv/plct_dpath.sv]
// Point store, odd-even sorter, slope divider, interpolator and color table.
module plct_dpath #(
    parameter int TABLE_LENGTH = 256,
    parameter int MAX_POINTS   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plct_pkg::t_in   i_item,
    input  plct_pkg::t_cmd  i_cmd,
    output plct_pkg::t_sts  o_sts,
    output plct_pkg::t_out  o_result
);
    import plct_pkg::*;

    localparam int AW = (TABLE_LENGTH > 1) ? $clog2(TABLE_LENGTH) : 1;
    localparam int PW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);

    t_point           r_pts [MAX_POINTS];
    logic [CW-1:0]    r_held;
    t_in              r_item;
    logic [IW-1:0]    r_sph;
    logic [AW-1:0]    r_clr;
    logic [CW-1:0]    r_rot;
    logic [2:0]       r_dcnt;
    logic [7:0]       r_dx;
    logic [7:0]       r_x1;
    logic [8:0]       r_j;
    logic [7:0]       r_dnum [4];
    logic [7:0]       r_drem [4];
    logic             r_dneg [4];
    logic signed [9:0] r_q [4];
    logic [8:0]       r_r [4];
    logic [31:0]      r_mem [TABLE_LENGTH];
    logic [31:0]      r_rd;
    logic             r_rd_ok;
    logic [1:0]       r_status;

    logic [1:0]       st;
    logic             ok_rebuild;
    t_point           pa, pb, new_pt;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [31:0]      mem_wd;
    logic signed [9:0] qd [4];
    logic [8:0]       rd [4];
    logic [7:0]       nq [4];
    logic signed [9:0] nq_full [4];
    logic [8:0]       nr [4];

    assign pa = r_pts[0];
    assign pb = r_pts[1];

    // Decode status of the held transaction
    always_comb begin
        st = ST_OK;
        ok_rebuild = 1'b0;
        if (r_item.op == OP_ADD) begin
            if (r_held >= CW'(MAX_POINTS)) st = ST_FULL;
            else ok_rebuild = 1'b1;
        end else if (r_item.op == OP_REMOVE) begin
            if (8'(r_item.point_slot) >= 8'(r_held)) st = ST_SLOT;
            else if (r_held <= CW'(2)) st = ST_FEW;
            else ok_rebuild = 1'b1;
        end
    end

    assign new_pt = '{pos: r_item.position, red: r_item.red_in, green: r_item.green_in,
                      blue: r_item.blue_in, alpha: r_item.alpha_in};

    // Hold the transaction and the response fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_item;
        if (i_cmd.apply) r_status <= st;
    end

    // Point store: insert, remove, sort phases and rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_POINTS; k++)
                r_pts[k] <= (k == 1)
                          ? '{pos: CH_MAX, red: CH_MAX, green: CH_MAX, blue: CH_MAX,
                              alpha: CH_MAX}
                          : '0;
            r_held <= CW'(2);
        end else if (i_cmd.apply && ok_rebuild) begin
            if (r_item.op == OP_ADD) begin
                r_pts[r_held[IW-1:0]] <= new_pt;
                r_held <= r_held + CW'(1);
            end else begin
                for (int k = 0; k < MAX_POINTS - 1; k++)
                    if (8'(k) >= 8'(r_item.point_slot)) r_pts[k] <= r_pts[k+1];
                r_held <= r_held - CW'(1);
            end
        end else if (i_cmd.sort_step) begin
            for (int k = 0; k < MAX_POINTS - 1; k++)
                if ((k % 2) == int'(r_sph[0]) && CW'(k + 1) < r_held
                    && r_pts[k].pos > r_pts[k+1].pos) begin
                    r_pts[k]   <= r_pts[k+1];
                    r_pts[k+1] <= r_pts[k];
                end
        end else if (i_cmd.rotate) begin
            for (int k = 0; k < MAX_POINTS - 1; k++) r_pts[k] <= r_pts[k+1];
            r_pts[MAX_POINTS-1] <= r_pts[0];
        end
    end

    // Sequence counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sph  <= '0;
            r_clr  <= '0;
            r_rot  <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.sort_step) r_sph <= o_sts.sort_last ? '0 : r_sph + IW'(1);
            if (i_cmd.clr_step)  r_clr <= o_sts.clr_last ? '0 : r_clr + AW'(1);
            if (i_cmd.rot_clr)   r_rot <= '0;
            else if (i_cmd.rotate) r_rot <= r_rot + CW'(1);
            if (i_cmd.put_a)     r_dcnt <= '0;
            else if (i_cmd.div_step) r_dcnt <= r_dcnt + 3'd1;
        end
    end

    // Floor slope terms from the divider result
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (!r_dneg[c]) begin
                qd[c] = $signed({2'b00, r_dnum[c]});
                rd[c] = {1'b0, r_drem[c]};
            end else if (r_drem[c] == 8'd0) begin
                qd[c] = -$signed({2'b00, r_dnum[c]});
                rd[c] = 9'd0;
            end else begin
                qd[c] = -$signed({2'b00, r_dnum[c]}) - 10'sd1;
                rd[c] = {1'b0, r_dx - r_drem[c]};
            end
            nr[c] = r_r[c] + rd[c];
            nq_full[c] = r_q[c] + qd[c] + ((nr[c] >= {1'b0, r_dx}) ? 10'sd1 : 10'sd0);
            nq[c] = nq_full[c][7:0];
        end
    end

    // Segment setup, serial slope divide and interpolation step
    always_ff @(posedge i_clk) begin
        logic [8:0] rem_s;
        if (i_cmd.put_a) begin
            r_dx <= pb.pos - pa.pos;
            r_x1 <= pb.pos;
            r_j  <= {1'b0, pa.pos} + 9'd1;
            for (int c = 0; c < 4; c++) begin
                r_dneg[c] <= point_ch(pb, 2'(c)) < point_ch(pa, 2'(c));
                r_dnum[c] <= (point_ch(pb, 2'(c)) < point_ch(pa, 2'(c)))
                           ? point_ch(pa, 2'(c)) - point_ch(pb, 2'(c))
                           : point_ch(pb, 2'(c)) - point_ch(pa, 2'(c));
                r_drem[c] <= '0;
                r_q[c]    <= $signed({2'b00, point_ch(pa, 2'(c))});
                r_r[c]    <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < 4; c++) begin
                rem_s = {r_drem[c], r_dnum[c][7]};
                if (rem_s >= {1'b0, r_dx}) begin
                    r_drem[c] <= 8'(rem_s - {1'b0, r_dx});
                    r_dnum[c] <= {r_dnum[c][6:0], 1'b1};
                end else begin
                    r_drem[c] <= rem_s[7:0];
                    r_dnum[c] <= {r_dnum[c][6:0], 1'b0};
                end
            end
        end else if (i_cmd.interp_step) begin
            r_j <= r_j + 9'd1;
            for (int c = 0; c < 4; c++) begin
                r_q[c] <= nq_full[c];
                r_r[c] <= (nr[c] >= {1'b0, r_dx}) ? nr[c] - {1'b0, r_dx} : nr[c];
            end
        end
    end

    // Table write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        priority if (i_cmd.clr_step) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
        end else if (i_cmd.put_a) begin
            mem_we = PW'(pa.pos) < PW'(TABLE_LENGTH);
            mem_wa = AW'(pa.pos);
            mem_wd = {pa.red, pa.green, pa.blue, pa.alpha};
        end else if (i_cmd.put_b) begin
            mem_we = PW'(pb.pos) < PW'(TABLE_LENGTH);
            mem_wa = AW'(pb.pos);
            mem_wd = {pb.red, pb.green, pb.blue, pb.alpha};
        end else if (i_cmd.interp_step) begin
            mem_we = 1'b1;
            mem_wa = AW'(r_j);
            mem_wd = {nq[0], nq[1], nq[2], nq[3]};
        end
    end

    // Color table memory with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.apply) begin
            r_rd    <= r_mem[AW'(r_item.entry_index)];
            r_rd_ok <= (r_item.op == OP_READ)
                    && (PW'(r_item.entry_index) < PW'(TABLE_LENGTH));
        end
    end

    // Status to the controller
    assign o_sts.rebuild    = ok_rebuild;
    assign o_sts.sort_last  = (r_sph == IW'(MAX_POINTS - 1));
    assign o_sts.clr_last   = (r_clr == AW'(TABLE_LENGTH - 1));
    assign o_sts.seg_more   = (r_rot + CW'(1)) < r_held;
    assign o_sts.div_last   = (r_dcnt == 3'd7);
    assign o_sts.interp_run = (r_j < {1'b0, r_x1}) && (PW'(r_j) < PW'(TABLE_LENGTH));
    assign o_sts.rot_full   = (r_rot == CW'(MAX_POINTS));

    // Response fields
    assign o_result.status      = r_status;
    assign o_result.red_out     = r_rd_ok ? r_rd[31:24] : 8'd0;
    assign o_result.green_out   = r_rd_ok ? r_rd[23:16] : 8'd0;
    assign o_result.blue_out    = r_rd_ok ? r_rd[15:8]  : 8'd0;
    assign o_result.alpha_out   = r_rd_ok ? r_rd[7:0]   : 8'd0;
    assign o_result.point_count = 5'(r_held);

    // Point count stays within the legal range
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held >= CW'(2)) && (r_held <= CW'(MAX_POINTS)))
        else $error("point count out of range");

    // Interpolation remainder of the red and alpha lanes stays below the segment width
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.interp_step |-> (r_r[0] < {1'b0, r_dx}) && (r_r[3] < {1'b0, r_dx}))
        else $error("interpolation remainder overflow");

    // Interior writes never reach the right end point
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.interp_step |-> (r_j < {1'b0, r_x1}))
        else $error("interior write past segment end");

    // Rotation never passes a full turn
    a_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rotate |-> (r_rot < CW'(MAX_POINTS)))
        else $error("point rotation overrun");

endmodule

[sv/piecewise_linear_color_table_core.sv]
// Top level of the piecewise linear RGBA color table.
//
// Usage: drive i_cmd and raise i_start; the transaction is taken on a rising
// edge with i_start high and o_busy low. Each transaction gives exactly one
// result on o_result, marked by o_valid for one cycle; the receiver cannot
// stall it. o_busy stays high from acceptance through the result cycle.
//
// Sequence: a read or a rejected add/remove passes the decode state and
// shows its result in the response state; the next transaction can be taken
// once o_busy is low again, so transactions never overlap. An accepted add or
// remove rebuilds the table: a decode step, MAX_POINTS sort phases, a clear
// of all TABLE_LENGTH entries, then per segment a setup that writes both end
// points, a serial slope divide and one write per interior entry, then
// MAX_POINTS-(points-1) restore rotations and the final and response states;
// its length is set by the single table write port and the slope divider.
//
// Reset (synchronous, active low) loads the two default end points and
// builds the ramp, starting at the table clear; during the build o_busy is
// high and no result is given.
module piecewise_linear_color_table_core #(
    parameter int TABLE_LENGTH = 256,
    parameter int MAX_POINTS   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  plct_pkg::t_in  i_cmd,
    output logic           o_busy,
    output logic           o_valid,
    output plct_pkg::t_out o_result
);
    import plct_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    plct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    // Datapath
    plct_dpath #(
        .TABLE_LENGTH (TABLE_LENGTH),
        .MAX_POINTS   (MAX_POINTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_cmd),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

[bench/piecewise_linear_color_table_core_tb.sv]
// Testbench for the piecewise linear color table core: scoreboard class, stimulus tasks, checks.
`timescale 1ns / 100ps

module piecewise_linear_color_table_core_tb;
    import plct_pkg::*;

    localparam int TBL_LEN  = 256;
    localparam int PT_MAX   = 16;
    localparam int LIMIT_CYCLES = 4000000;

    // Color table predictor with its own point list and table
    class color_table_scoreboard;
        t_point pts[PT_MAX];
        int unsigned held;
        logic [7:0] tbl[TBL_LEN][4];
        t_out pending[$];
        int errors;

        function new();
            errors = 0;
            for (int i = 0; i < PT_MAX; i++) pts[i] = '0;
            pts[1] = {8'd255, CH_MAX, CH_MAX, CH_MAX, CH_MAX};
            held = 2;
            rebuild();
        endfunction

        function int unsigned chan(t_point p, int c);
            case (c)
                0: return p.red;
                1: return p.green;
                2: return p.blue;
                default: return p.alpha;
            endcase
        endfunction

        function void put(int unsigned idx, t_point p);
            if (idx >= TBL_LEN) return;
            for (int c = 0; c < 4; c++) tbl[idx][c] = 8'(chan(p, c));
        endfunction

        function void sort_list();
            t_point t;
            for (int i = 0; i + 1 < held; i++)
                for (int j = 0; j + 1 < held - i; j++)
                    if (pts[j].pos > pts[j+1].pos) begin
                        t = pts[j]; pts[j] = pts[j+1]; pts[j+1] = t;
                    end
        endfunction

        function void rebuild();
            int x0, x1, f0, f1, num;
            for (int j = 0; j < TBL_LEN; j++)
                for (int c = 0; c < 4; c++) tbl[j][c] = '0;
            for (int i = 0; i + 1 < held; i++) begin
                x0 = pts[i].pos;
                x1 = pts[i+1].pos;
                put(x0, pts[i]);
                put(x1, pts[i+1]);
                for (int j = x0 + 1; j < x1 && j < TBL_LEN; j++)
                    for (int c = 0; c < 4; c++) begin
                        f0 = chan(pts[i], c);
                        f1 = chan(pts[i+1], c);
                        num = f0 * (x1 - x0) + (f1 - f0) * (j - x0);
                        if (num < 0) num = 0;
                        tbl[j][c] = 8'(num / (x1 - x0));
                    end
            end
        endfunction

        // Note an accepted transaction and queue its expected result
        function void note_command(t_in cmd);
            t_out r;
            r = '0;
            if (cmd.op == OP_ADD) begin
                if (held >= PT_MAX) r.status = ST_FULL;
                else begin
                    pts[held] = {cmd.position, cmd.red_in, cmd.green_in, cmd.blue_in,
                                 cmd.alpha_in};
                    held++;
                    sort_list();
                    rebuild();
                end
            end else if (cmd.op == OP_REMOVE) begin
                if (cmd.point_slot >= held) r.status = ST_SLOT;
                else if (held <= 2) r.status = ST_FEW;
                else begin
                    for (int k = cmd.point_slot; k + 1 < held; k++) pts[k] = pts[k+1];
                    held--;
                    sort_list();
                    rebuild();
                end
            end else if (cmd.op == OP_READ) begin
                r.red_out   = tbl[cmd.entry_index][0];
                r.green_out = tbl[cmd.entry_index][1];
                r.blue_out  = tbl[cmd.entry_index][2];
                r.alpha_out = tbl[cmd.entry_index][3];
            end
            r.point_count = held[4:0];
            pending.insert(pending.size(), r);
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            if (got.red_out !== exp_r.red_out)
                $display("%0t: red exp %0d got %0d", $time, exp_r.red_out, got.red_out);
            if (got.green_out !== exp_r.green_out)
                $display("%0t: green exp %0d got %0d", $time, exp_r.green_out, got.green_out);
            if (got.blue_out !== exp_r.blue_out)
                $display("%0t: blue exp %0d got %0d", $time, exp_r.blue_out, got.blue_out);
            if (got.alpha_out !== exp_r.alpha_out)
                $display("%0t: alpha exp %0d got %0d", $time, exp_r.alpha_out, got.alpha_out);
            if (got.point_count !== exp_r.point_count)
                $display("%0t: count exp %0d got %0d", $time, exp_r.point_count,
                         got.point_count);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  i_cmd = '0;
    logic o_busy, o_valid;
    t_out o_result;

    color_table_scoreboard sb;
    int idle_pct = 0;
    int cycles = 0;

    piecewise_linear_color_table_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_valid(o_valid), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Check results, note accepted transactions, watch the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) sb.check_result(o_result);
        if (i_rst_n && i_start && !o_busy) sb.note_command(i_cmd);
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Issue one transaction, with a random idle gap before it
    task automatic send_cmd(t_in cmd);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge i_clk);
        i_cmd <= cmd;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in rand_cmd(logic [1:0] op);
        t_in c;
        c = t_in'({$urandom, $urandom});
        c.op = op;
        return c;
    endfunction

    task automatic send_add(int pos, int a, int r, int g, int b);
        t_in c;
        c = rand_cmd(OP_ADD);
        c.position = 8'(pos); c.alpha_in = 8'(a); c.red_in = 8'(r);
        c.green_in = 8'(g); c.blue_in = 8'(b);
        send_cmd(c);
    endtask

    task automatic send_read(int idx);
        t_in c;
        c = rand_cmd(OP_READ);
        c.entry_index = 8'(idx);
        send_cmd(c);
    endtask

    task automatic send_remove(int slot);
        t_in c;
        c = rand_cmd(OP_REMOVE);
        c.point_slot = 4'(slot);
        send_cmd(c);
    endtask

    initial begin
        int r;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default ramp, edge positions, equal positions, rejects, unused op
        send_read(0); send_read(128); send_read(255);
        send_remove(2);
        send_remove(0);
        send_add(100, 255, 0, 255, 0);
        send_add(100, 0, 255, 0, 255);
        send_read(100); send_read(50); send_read(180);
        send_add(255, 10, 20, 30, 40);
        send_add(0, 200, 200, 200, 200);
        send_remove(15);
        send_remove(1);
        send_read(99);
        send_cmd(rand_cmd(2'd3));
        for (int i = 0; i < 14; i++) send_add($urandom_range(255), 0, 255, 0, 255);
        send_read($urandom_range(255));
        send_remove(0);

        // Random phases with varying sender idling
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 77;
                2: idle_pct = 19;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 195; n++) begin
                r = $urandom_range(99);
                if (r < 60) send_read($urandom_range(255));
                else if (r < 78) send_cmd(rand_cmd(OP_ADD));
                else if (r < 97) send_remove($urandom_range(sb.held + 1));
                else if (r < 99) send_cmd(rand_cmd(OP_REMOVE));
                else send_cmd(rand_cmd(2'd3));
            end
            // Hold until every pending result has come back
            while (sb.pending.size() != 0) @(posedge i_clk);
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
